[rtl/iwasd_pkg.sv]
`default_nettype none
package iwasd_pkg;

    localparam int WinLog2 = 4;
    localparam int Window  = 1 << WinLog2;
    localparam int SlotW   = WinLog2;

    localparam int LaneW   = 25;               // 16-bit signed or 24-bit unsigned, extended
    localparam int LaneSumW = LaneW + WinLog2;

    localparam int AccW    = 16;
    localparam int AccSumW = AccW + WinLog2;
    localparam int SqW     = 2 * AccW;
    localparam int SqSumW  = SqW + WinLog2 - 1 + 1;  // +1 for the full-scale negative square
    localparam int NumW    = SqSumW + WinLog2;
    localparam int DivW    = NumW - WinLog2;        // floor(num / N)
    localparam int RecFracW = 8;                    // guard bits for the series
    localparam int RecW    = DivW + RecFracW;
    localparam int RecSteps = 4;                    // factors (1 + 2^-(4 << k)), k = 0..3
    localparam int FixW    = DivW + 1;
    localparam int RadW    = 32;
    localparam int RootW   = RadW / 2;
    localparam int RemW    = RootW + 3;
    localparam int StepCntW = 5;

    localparam int ThrW    = 17;
    localparam logic [ThrW-1:0] ThrReset = ThrW'(64);
    localparam int TotalW  = RootW + 2;

    typedef struct packed {
        logic load;
        logic prefill;
    } lane_ctl_t;

    typedef enum logic [3:0] {
        DEV_IDLE,
        DEV_SQ,
        DEV_ACC,
        DEV_MUL,
        DEV_NUM,
        DEV_DIV,
        DEV_FIX,
        DEV_SQRT,
        DEV_FIN
    } dev_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } top_state_t;

endpackage
`default_nettype wire

[rtl/imu_window_average_still_detect.sv]
`default_nettype none
// channel   dir  beat contents
// s_axis    in   tuser: req_type; tdata: accel x/y/z, magnet x/y/z, pressure
// m_axis    out  tdata: avg accel x/y/z, avg magnet x/y/z, avg pressure, is_still
// cfg       in   cfg_wdata: still_threshold, written when cfg_we is high
//
// One beat in flight: a new input beat is taken only after the result of the last one is done.
// The per-axis deviation unit steps through SQ, ACC, MUL and NUM to set up, DIV for the
// series and FIX for the correction of the division by N-1, SQRT for the root, then FIN.
// A finished result waits in the output register; the next beat is taken meanwhile.
// If that register is still full at the next result, s_tready stays low until it drains.
// Reset clears the window, sums and slot pointer, and sets the threshold to 64.
module imu_window_average_still_detect (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,   // accel_x, accel_y, accel_z, magnet_x,
                                         // magnet_y, magnet_z, pressure_raw
    input  wire logic         s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // avg_accel_x/y/z, avg_magnet_x/y/z,
                                         // avg_pressure, is_still, zero pad
    input  wire logic         cfg_we,
    input  wire logic [16:0]  cfg_wdata
);

    localparam int NumLanes = 7;

    iwasd_pkg::top_state_t state_reg, state_next;

    logic [iwasd_pkg::ThrW-1:0]   thr_reg;
    logic [iwasd_pkg::SlotW-1:0]  slot_reg;
    logic [iwasd_pkg::SlotW-1:0]  slot_use;
    logic                         m_tvalid_reg;
    logic [127:0]                 m_tdata_reg;
    logic                         accept, out_free, load_out;

    iwasd_pkg::lane_ctl_t ctl;

    logic signed [iwasd_pkg::LaneW-1:0]    lane_in  [NumLanes];
    logic signed [iwasd_pkg::LaneW-1:0]    lane_old [NumLanes];
    logic signed [iwasd_pkg::LaneSumW-1:0] lane_sum [NumLanes];
    logic [iwasd_pkg::RootW-1:0]           std_dev  [3];
    logic [2:0]                            dev_done;
    logic                                  all_done;
    logic [iwasd_pkg::TotalW-1:0]          total;
    logic                                  still;
    logic [127:0]                          result;

    assign accept      = s_tvalid && s_tready;
    assign ctl.load    = accept;
    assign ctl.prefill = s_tuser;
    assign slot_use    = s_tuser ? '0 : slot_reg;

    genvar g;
    generate
        for (g = 0; g < 6; g++) begin : g_ext
            assign lane_in[g] = iwasd_pkg::LaneW'($signed(s_tdata[16*g +: 16]));
        end
    endgenerate
    assign lane_in[6] = $signed({1'b0, s_tdata[96 +: 24]});

    generate
        for (g = 0; g < NumLanes; g++) begin : g_lane
            iwasd_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .slot    (slot_use),
                .sample  (lane_in[g]),
                .old_val (lane_old[g]),
                .sum     (lane_sum[g])
            );
        end
        for (g = 0; g < 3; g++) begin : g_dev
            iwasd_dev u_dev (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .new_val (lane_in[g][iwasd_pkg::AccW-1:0]),
                .old_val (lane_old[g][iwasd_pkg::AccW-1:0]),
                .sum     (lane_sum[g][iwasd_pkg::AccSumW-1:0]),
                .std_dev (std_dev[g]),
                .done    (dev_done[g])
            );
        end
    endgenerate

    // the three deviation units run in lockstep
    assign all_done = &dev_done;

    // merge: summed deviations against the threshold, means by dropping low bits
    assign total = iwasd_pkg::TotalW'(std_dev[0]) + iwasd_pkg::TotalW'(std_dev[1])
                 + iwasd_pkg::TotalW'(std_dev[2]);
    assign still = (total < iwasd_pkg::TotalW'(thr_reg));

    always_comb begin
        result = '0;
        for (int i = 0; i < 6; i++) begin
            result[16*i +: 16] = lane_sum[i][iwasd_pkg::WinLog2 +: 16];
        end
        result[96 +: 24] = lane_sum[6][iwasd_pkg::WinLog2 +: 24];
        result[120]      = still;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iwasd_pkg::ST_IDLE: if (accept) state_next = iwasd_pkg::ST_BUSY;
            iwasd_pkg::ST_BUSY: begin
                if (all_done)
                    state_next = out_free ? iwasd_pkg::ST_IDLE : iwasd_pkg::ST_HOLD;
            end
            iwasd_pkg::ST_HOLD: if (out_free) state_next = iwasd_pkg::ST_IDLE;
            default:            state_next = iwasd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == iwasd_pkg::ST_IDLE);
        load_out = out_free && ((state_reg == iwasd_pkg::ST_BUSY && all_done)
                                || state_reg == iwasd_pkg::ST_HOLD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= iwasd_pkg::ST_IDLE;
            thr_reg      <= iwasd_pkg::ThrReset;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) thr_reg <= cfg_wdata;
            if (accept) slot_reg <= slot_use + 1'b1;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) m_tdata_reg <= result;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[rtl/iwasd_lane.sv]
`default_nettype none
module iwasd_lane (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire iwasd_pkg::lane_ctl_t                 ctl,
    input  wire logic [iwasd_pkg::SlotW-1:0]          slot,
    input  wire logic signed [iwasd_pkg::LaneW-1:0]   sample,
    output logic signed [iwasd_pkg::LaneW-1:0]       old_val,
    output logic signed [iwasd_pkg::LaneSumW-1:0]    sum
);

    logic signed [iwasd_pkg::LaneW-1:0]    hist_reg [iwasd_pkg::Window];
    logic [iwasd_pkg::Window-1:0]          valid_reg;
    logic signed [iwasd_pkg::LaneW-1:0]    fill_reg;
    logic signed [iwasd_pkg::LaneSumW-1:0] sum_reg;
    logic signed [iwasd_pkg::LaneSumW-1:0] sum_next;

    // slots not written since the last prefill read back the fill value
    assign old_val = valid_reg[slot] ? hist_reg[slot] : fill_reg;
    assign sum     = sum_reg;

    always_comb begin
        if (ctl.prefill) begin
            sum_next = iwasd_pkg::LaneSumW'(sample) <<< iwasd_pkg::WinLog2;
        end else begin
            sum_next = sum_reg + iwasd_pkg::LaneSumW'(sample)
                     - iwasd_pkg::LaneSumW'(old_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end else if (ctl.load) begin
            sum_reg <= sum_next;
            if (ctl.prefill) begin
                fill_reg  <= sample;
                valid_reg <= '0;
            end else begin
                valid_reg[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load && !ctl.prefill) begin
            hist_reg[slot] <= sample;
        end
    end

endmodule
`default_nettype wire

[rtl/iwasd_dev.sv]
`default_nettype none
module iwasd_dev (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire iwasd_pkg::lane_ctl_t                  ctl,
    input  wire logic signed [iwasd_pkg::AccW-1:0]     new_val,
    input  wire logic signed [iwasd_pkg::AccW-1:0]     old_val,
    input  wire logic signed [iwasd_pkg::AccSumW-1:0]  sum,
    output logic [iwasd_pkg::RootW-1:0]               std_dev,
    output logic                                      done
);

    iwasd_pkg::dev_state_t state_reg, state_next;

    logic signed [iwasd_pkg::AccW-1:0]   new_reg, old_reg;
    logic                                pre_reg;
    logic [iwasd_pkg::SqW-1:0]           sq_new_reg, sq_old_reg;
    logic [iwasd_pkg::SqSumW-1:0]        sqsum_reg;
    logic [iwasd_pkg::NumW-1:0]          s2_reg;
    logic [iwasd_pkg::DivW-1:0]          div_reg;
    logic [iwasd_pkg::RecW-1:0]          rec_reg;
    logic [iwasd_pkg::RadW-1:0]          rad_reg;
    logic [iwasd_pkg::RemW-1:0]          rem_reg;
    logic [iwasd_pkg::RootW-1:0]         root_reg;
    logic [iwasd_pkg::StepCntW-1:0]      cnt_reg;

    logic signed [2*iwasd_pkg::AccW-1:0]    prod_new, prod_old;
    logic signed [2*iwasd_pkg::AccSumW-1:0] prod_sum;
    logic [iwasd_pkg::NumW-1:0]             scaled;
    logic [iwasd_pkg::DivW-1:0]             num_div;
    logic [5:0]                             rec_shift;
    logic [iwasd_pkg::RadW-1:0]             q_est;
    logic [iwasd_pkg::FixW-1:0]             fix_lhs, fix_rhs;
    logic                                   q_bump;
    logic [iwasd_pkg::RemW-1:0]             rem_t, trial;

    assign prod_new = new_reg * new_reg;
    assign prod_old = old_reg * old_reg;
    assign prod_sum = sum * sum;
    assign scaled   = {sqsum_reg, {iwasd_pkg::WinLog2{1'b0}}};

    // floor(num / (N*(N-1))) = floor(floor(num / N) / (N-1))
    always_comb begin
        if (scaled > s2_reg) begin
            num_div = iwasd_pkg::DivW'((scaled - s2_reg) >> iwasd_pkg::WinLog2);
        end else begin
            num_div = '0;
        end
    end

    // x/(N-1) = (x/N) * (1 + 2^-4)(1 + 2^-8)(1 + 2^-16)(1 + 2^-32), one factor a cycle;
    // truncation leaves the estimate at most one low, fixed by one compare
    assign rec_shift = 6'(iwasd_pkg::WinLog2) << cnt_reg[1:0];
    assign q_est     = rec_reg[iwasd_pkg::WinLog2 + iwasd_pkg::RecFracW +: iwasd_pkg::RadW];
    assign fix_lhs   = iwasd_pkg::FixW'(div_reg) + iwasd_pkg::FixW'(q_est);
    assign fix_rhs   = (iwasd_pkg::FixW'(q_est) << iwasd_pkg::WinLog2)
                     + iwasd_pkg::FixW'(iwasd_pkg::Window - 1);
    assign q_bump    = (fix_lhs >= fix_rhs);   // x >= (N-1)*(q+1)

    // digit-by-digit square root, one root bit per cycle
    assign rem_t = {rem_reg[iwasd_pkg::RemW-3:0], rad_reg[iwasd_pkg::RadW-1 -: 2]};
    assign trial = iwasd_pkg::RemW'({root_reg, 2'b01});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iwasd_pkg::DEV_IDLE: if (ctl.load) state_next = iwasd_pkg::DEV_SQ;
            iwasd_pkg::DEV_SQ:   state_next = iwasd_pkg::DEV_ACC;
            iwasd_pkg::DEV_ACC:  state_next = iwasd_pkg::DEV_MUL;
            iwasd_pkg::DEV_MUL:  state_next = iwasd_pkg::DEV_NUM;
            iwasd_pkg::DEV_NUM:  state_next = iwasd_pkg::DEV_DIV;
            iwasd_pkg::DEV_DIV: begin
                if (cnt_reg == iwasd_pkg::StepCntW'(iwasd_pkg::RecSteps - 1))
                    state_next = iwasd_pkg::DEV_FIX;
            end
            iwasd_pkg::DEV_FIX:  state_next = iwasd_pkg::DEV_SQRT;
            iwasd_pkg::DEV_SQRT: begin
                if (cnt_reg == iwasd_pkg::StepCntW'(iwasd_pkg::RootW - 1))
                    state_next = iwasd_pkg::DEV_FIN;
            end
            iwasd_pkg::DEV_FIN:  state_next = iwasd_pkg::DEV_IDLE;
            default:             state_next = iwasd_pkg::DEV_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == iwasd_pkg::DEV_FIN);
    end

    assign std_dev = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iwasd_pkg::DEV_IDLE;
            sqsum_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == iwasd_pkg::DEV_ACC) begin
                if (pre_reg) begin
                    sqsum_reg <= iwasd_pkg::SqSumW'(sq_new_reg) << iwasd_pkg::WinLog2;
                end else begin
                    sqsum_reg <= sqsum_reg - iwasd_pkg::SqSumW'(sq_old_reg)
                               + iwasd_pkg::SqSumW'(sq_new_reg);
                end
            end
            if ((state_reg == iwasd_pkg::DEV_NUM) || (state_reg == iwasd_pkg::DEV_FIX)) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            iwasd_pkg::DEV_IDLE: begin
                if (ctl.load) begin
                    new_reg <= new_val;
                    old_reg <= old_val;
                    pre_reg <= ctl.prefill;
                end
            end
            iwasd_pkg::DEV_SQ: begin
                sq_new_reg <= prod_new[iwasd_pkg::SqW-1:0];
                sq_old_reg <= prod_old[iwasd_pkg::SqW-1:0];
            end
            iwasd_pkg::DEV_MUL: begin
                s2_reg <= prod_sum[iwasd_pkg::NumW-1:0];
            end
            iwasd_pkg::DEV_NUM: begin
                div_reg <= num_div;
                rec_reg <= {num_div, {iwasd_pkg::RecFracW{1'b0}}};
            end
            iwasd_pkg::DEV_DIV: begin
                rec_reg <= rec_reg + (rec_reg >> rec_shift);
            end
            iwasd_pkg::DEV_FIX: begin
                rad_reg  <= q_est + iwasd_pkg::RadW'(q_bump);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            iwasd_pkg::DEV_SQRT: begin
                rad_reg <= rad_reg << 2;
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[iwasd_pkg::RootW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[iwasd_pkg::RootW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/iwasd_checker.sv]
`default_nettype none
module iwasd_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata
);

    a_out_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input beat taken while one is in work");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result beat appeared one cycle after input");

endmodule

bind imu_window_average_still_detect iwasd_checker u_iwasd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
